>>> hdl/krle_pkg.sv
package krle_pkg;

	localparam int KEY_W = 32;
	localparam int CMD_W = 4;

	localparam logic [CMD_W-1:0] CMD_APPEND    = 4'd0;
	localparam logic [CMD_W-1:0] CMD_PREPEND   = 4'd1;
	localparam logic [CMD_W-1:0] CMD_ORDERED   = 4'd2;
	localparam logic [CMD_W-1:0] CMD_REM_SHIFT = 4'd3;
	localparam logic [CMD_W-1:0] CMD_REM_SWAP  = 4'd4;
	localparam logic [CMD_W-1:0] CMD_REM_FIRST = 4'd5;
	localparam logic [CMD_W-1:0] CMD_REM_LAST  = 4'd6;
	localparam logic [CMD_W-1:0] CMD_GET_POS   = 4'd7;
	localparam logic [CMD_W-1:0] CMD_GET_KEY   = 4'd8;

	typedef struct packed {
		logic ins;
		logic rm_shift;
		logic rm_swap;
	} wr_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

endpackage

>>> hdl/krle_cell.sv
module krle_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7,
	parameter int PW  = 64
) (
	input  logic                          clk,
	input  logic                          load,
	input  logic [krle_pkg::CMD_W-1:0]    cmd,
	input  logic [krle_pkg::KEY_W-1:0]    key,
	input  logic [CW-1:0]                 pos,
	input  logic [CW-1:0]                 count,
	input  krle_pkg::wr_ctrl_t            wr,
	input  logic                          ins_seen_in,
	input  logic                          hit_seen_in,
	output logic                          ins_seen_out,
	output logic                          hit_seen_out,
	output logic                          first_hit,
	input  logic [krle_pkg::KEY_W-1:0]    new_key,
	input  logic [PW-1:0]                 new_pay,
	input  logic [krle_pkg::KEY_W-1:0]    left_key,
	input  logic [PW-1:0]                 left_pay,
	input  logic [krle_pkg::KEY_W-1:0]    right_key,
	input  logic [PW-1:0]                 right_pay,
	input  logic [krle_pkg::KEY_W-1:0]    last_key,
	input  logic [PW-1:0]                 last_pay,
	output logic [krle_pkg::KEY_W-1:0]    cell_key,
	output logic [PW-1:0]                 cell_pay
);

	logic [krle_pkg::KEY_W-1:0] key_q;
	logic [PW-1:0]              pay_q;
	logic                       ins_s1;
	logic                       hit_s1;
	logic                       valid;
	logic                       ins_flag;
	logic                       hit_flag;
	logic                       first_ins;

	assign valid = CW'(IDX) < count;

	always_comb begin
		ins_flag = 1'b0;
		hit_flag = 1'b0;
		unique case (cmd)
			krle_pkg::CMD_APPEND: begin
				ins_flag = ~valid;
			end
			krle_pkg::CMD_PREPEND: begin
				ins_flag = (IDX == 0);
			end
			krle_pkg::CMD_ORDERED: begin
				ins_flag = ~valid | ($signed(key_q) >= $signed(key));
			end
			krle_pkg::CMD_REM_SHIFT, krle_pkg::CMD_REM_SWAP, krle_pkg::CMD_GET_KEY: begin
				hit_flag = valid & (key_q == key);
			end
			krle_pkg::CMD_REM_FIRST: begin
				hit_flag = valid & (IDX == 0);
			end
			krle_pkg::CMD_GET_POS: begin
				hit_flag = valid & (pos == CW'(IDX + 1));
			end
			default: begin
				ins_flag = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ins_s1 <= ins_flag;
			hit_s1 <= hit_flag;
		end
	end

	assign first_ins    = ins_s1 & ~ins_seen_in;
	assign ins_seen_out = ins_seen_in | ins_s1;
	assign first_hit    = hit_s1 & ~hit_seen_in;
	assign hit_seen_out = hit_seen_in | hit_s1;

	always_ff @(posedge clk) begin
		priority if (wr.ins && first_ins) begin
			key_q <= new_key;
			pay_q <= new_pay;
		end else if (wr.ins && ins_seen_in) begin
			key_q <= left_key;
			pay_q <= left_pay;
		end else if (wr.rm_shift && hit_seen_out) begin
			key_q <= right_key;
			pay_q <= right_pay;
		end else if (wr.rm_swap && first_hit) begin
			key_q <= last_key;
			pay_q <= last_pay;
		end else begin
			key_q <= key_q;
			pay_q <= pay_q;
		end
	end

	assign cell_key = key_q;
	assign cell_pay = pay_q;

endmodule

>>> hdl/keyed_record_list_engine.sv
// Fixed-capacity list of records (signed 32-bit key plus payload) held in a row of
// CAPACITY cells, each owning one position and talking to its two neighbours. Every
// command beat returns exactly one result beat with status, found record, count and
// full/empty flags. On acceptance a command loads the key comparison flags into
// every cell; in the execute state the engine resolves the first matching cell along
// the chain and shifts, swaps or reads the records in one step. The next command is
// taken in the cycle after the previous one commits, never while one is pending; a
// stalled result register holds the execute state until it drains.
module keyed_record_list_engine #(
	parameter int CAPACITY      = 64,
	parameter int PAYLOAD_WIDTH = 64,
	localparam int CW    = $clog2(CAPACITY + 1),
	localparam int S_RAW = krle_pkg::KEY_W + CW + PAYLOAD_WIDTH,
	localparam int S_W   = ((S_RAW + 7) / 8) * 8,
	localparam int M_RAW = krle_pkg::KEY_W + PAYLOAD_WIDTH + CW + 2,
	localparam int M_W   = ((M_RAW + 7) / 8) * 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [S_W-1:0]             s_tdata,  // key, position, payload, zero fill
	input  logic [krle_pkg::CMD_W-1:0] s_tuser,  // command
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [M_W-1:0]             m_tdata,  // found_key, found_payload, entry_count,
	                                             // is_full, is_empty, zero fill
	output logic                       m_tuser   // status
);

	localparam int KW = krle_pkg::KEY_W;

	krle_pkg::state_t           state_q;
	logic [CW-1:0]              count_q;
	logic [krle_pkg::CMD_W-1:0] cmd_s1;
	logic [KW-1:0]              key_s1;
	logic [PAYLOAD_WIDTH-1:0]   pay_s1;
	logic [KW-1:0]              last_key_s1;
	logic [PAYLOAD_WIDTH-1:0]   last_pay_s1;

	logic                       m_tvalid_q;
	logic                       status_q;
	logic [KW-1:0]              found_key_q;
	logic [PAYLOAD_WIDTH-1:0]   found_pay_q;
	logic [CW-1:0]              out_count_q;
	logic                       full_q;
	logic                       empty_q;

	logic [KW-1:0]              in_key;
	logic [CW-1:0]              in_pos;
	logic [PAYLOAD_WIDTH-1:0]   in_pay;
	logic                       accept;
	logic                       commit;

	logic [KW-1:0]              cell_key  [CAPACITY];
	logic [PAYLOAD_WIDTH-1:0]   cell_pay  [CAPACITY];
	logic                       first_hit [CAPACITY];
	logic [CAPACITY:0]          ins_seen;
	logic [CAPACITY:0]          hit_seen;

	krle_pkg::wr_ctrl_t         wr;
	logic                       ok;
	logic                       show;
	logic [CW-1:0]              next_count;
	logic                       not_full;
	logic                       not_empty;
	logic                       any_hit;
	logic [KW-1:0]              last_key;
	logic [PAYLOAD_WIDTH-1:0]   last_pay;
	logic [KW-1:0]              hit_key;
	logic [PAYLOAD_WIDTH-1:0]   hit_pay;

	assign in_key = s_tdata[KW-1:0];
	assign in_pos = s_tdata[KW +: CW];
	assign in_pay = s_tdata[KW + CW +: PAYLOAD_WIDTH];

	assign s_tready = (state_q == krle_pkg::ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign commit   = (state_q == krle_pkg::ST_EXEC) & (~m_tvalid_q | m_tready);

	assign ins_seen[0] = 1'b0;
	assign hit_seen[0] = 1'b0;
	assign any_hit     = hit_seen[CAPACITY];
	assign not_full    = count_q != CW'(CAPACITY);
	assign not_empty   = count_q != '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KW-1:0]            l_key;
		logic [PAYLOAD_WIDTH-1:0] l_pay;
		logic [KW-1:0]            r_key;
		logic [PAYLOAD_WIDTH-1:0] r_pay;

		if (i == 0) begin : g_first
			assign l_key = '0;
			assign l_pay = '0;
		end else begin : g_mid
			assign l_key = cell_key[i-1];
			assign l_pay = cell_pay[i-1];
		end

		if (i == CAPACITY - 1) begin : g_end
			assign r_key = '0;
			assign r_pay = '0;
		end else begin : g_inner
			assign r_key = cell_key[i+1];
			assign r_pay = cell_pay[i+1];
		end

		krle_cell #(
			.IDX(i),
			.CW (CW),
			.PW (PAYLOAD_WIDTH)
		) u_cell (
			.clk         (clk),
			.load        (accept),
			.cmd         (s_tuser),
			.key         (in_key),
			.pos         (in_pos),
			.count       (count_q),
			.wr          (wr),
			.ins_seen_in (ins_seen[i]),
			.hit_seen_in (hit_seen[i]),
			.ins_seen_out(ins_seen[i+1]),
			.hit_seen_out(hit_seen[i+1]),
			.first_hit   (first_hit[i]),
			.new_key     (key_s1),
			.new_pay     (pay_s1),
			.left_key    (l_key),
			.left_pay    (l_pay),
			.right_key   (r_key),
			.right_pay   (r_pay),
			.last_key    (last_key_s1),
			.last_pay    (last_pay_s1),
			.cell_key    (cell_key[i]),
			.cell_pay    (cell_pay[i])
		);
	end

	always_comb begin
		last_key = '0;
		last_pay = '0;
		hit_key  = '0;
		hit_pay  = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (count_q == CW'(i + 1)) begin
				last_key = last_key | cell_key[i];
				last_pay = last_pay | cell_pay[i];
			end
			if (first_hit[i]) begin
				hit_key = hit_key | cell_key[i];
				hit_pay = hit_pay | cell_pay[i];
			end
		end
	end

	always_comb begin
		ok         = 1'b0;
		show       = 1'b0;
		next_count = count_q;
		wr         = '0;
		unique case (cmd_s1)
			krle_pkg::CMD_APPEND, krle_pkg::CMD_PREPEND, krle_pkg::CMD_ORDERED: begin
				ok         = not_full;
				next_count = not_full ? count_q + CW'(1) : count_q;
				wr.ins     = not_full & commit;
			end
			krle_pkg::CMD_REM_SHIFT, krle_pkg::CMD_REM_FIRST: begin
				ok          = any_hit;
				next_count  = any_hit ? count_q - CW'(1) : count_q;
				wr.rm_shift = any_hit & commit;
			end
			krle_pkg::CMD_REM_SWAP: begin
				ok         = any_hit;
				next_count = any_hit ? count_q - CW'(1) : count_q;
				wr.rm_swap = any_hit & commit;
			end
			krle_pkg::CMD_REM_LAST: begin
				ok         = not_empty;
				next_count = not_empty ? count_q - CW'(1) : count_q;
			end
			krle_pkg::CMD_GET_POS, krle_pkg::CMD_GET_KEY: begin
				ok   = any_hit;
				show = any_hit;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= s_tuser;
			key_s1      <= in_key;
			pay_s1      <= in_pay;
			last_key_s1 <= last_key;
			last_pay_s1 <= last_pay;
		end
		if (commit) begin
			status_q    <= ~ok;
			found_key_q <= show ? hit_key : '0;
			found_pay_q <= show ? hit_pay : '0;
			out_count_q <= next_count;
			full_q      <= next_count == CW'(CAPACITY);
			empty_q     <= next_count == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= krle_pkg::ST_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				krle_pkg::ST_IDLE: begin
					if (accept) begin
						state_q <= krle_pkg::ST_EXEC;
					end
				end
				krle_pkg::ST_EXEC: begin
					if (commit) begin
						state_q <= krle_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= krle_pkg::ST_IDLE;
				end
			endcase
			if (commit) begin
				count_q    <= next_count;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {{(M_W - M_RAW){1'b0}}, empty_q, full_q, out_count_q, found_pay_q,
		found_key_q};

endmodule
